// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the hash table RTL. They expand to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define CHT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("hash table assertion failed");

// Condition must never be true at a rising clock edge outside reset.
`define CHT_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("hash table forbidden condition seen");

`else

`define CHT_ASSERT(label, clk, rst_n, prop)
`define CHT_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== sv/cht_pkg.sv =====
// ---------------------------------------------------------------------------
// Chained hash table package
// Field widths, operation and status codes, and the command and status
// bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

	// Field widths of the item and result channels.
	localparam int KEY_W    = 31;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int BUCKET_W = 3;
	localparam int POS_W    = 4;

	// Default table geometry.
	localparam int BUCKETS_DEF      = 8;
	localparam int BUCKET_DEPTH_DEF = 8;

	// The bucket index takes a reciprocal multiply, then a multiply-back and
	// subtract.
	localparam int MOD_STEPS = 2;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	// Operation codes. Any other code behaves as a find.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

	// Update applied to the bucket fill count when a result is posted.
	typedef enum logic [1:0] {
		FILL_KEEP,
		FILL_INC,
		FILL_DEC
	} fill_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                load;
		logic                mod_step;
		logic                fill_rd;
		logic                fill_ld;
		logic                shift_up;
		logic                scan;
		logic                shift_dn;
		logic                post;
		fill_op_t            fill_op;
		logic [STATUS_W-1:0] status;
	} cht_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mod_last;
		logic is_insert;
		logic is_delete;
		logic full;
		logic up_done;
		logic hit;
		logic miss;
		logic dn_done;
		logic out_free;
	} cht_stat_t;

endpackage

`default_nettype wire

// ===== sv/cht_req_if.sv =====
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one operation and key per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface cht_req_if;
	import cht_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [KEY_W-1:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink (input valid, input operation, input key, output ready);
endinterface

`default_nettype wire

// ===== sv/cht_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result item per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface cht_rsp_if;
	import cht_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BUCKET_W-1:0] bucket;
	logic [POS_W-1:0]    position;

	modport source (output valid, output status, output bucket, output position, input ready);
	modport sink (input valid, input status, input bucket, input position, output ready);
endinterface

`default_nettype wire

// ===== sv/cht_datapath.sv =====
// ---------------------------------------------------------------------------
// Hash table datapath
// Key and operation registers, the reciprocal modulo unit, the fill count
// memory, the key memory with its read and write pipeline, the key compare
// and the result output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cht_datapath #(
	parameter int BUCKETS      = cht_pkg::BUCKETS_DEF,
	parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire [cht_pkg::OP_W-1:0]          req_operation,
	input  wire [cht_pkg::KEY_W-1:0]         req_key,
	input  wire cht_pkg::cht_cmd_t           cmd,
	output cht_pkg::cht_stat_t               stat,
	output logic                             rsp_valid,
	input  wire                              rsp_ready,
	output logic [cht_pkg::STATUS_W-1:0]     rsp_status,
	output logic [cht_pkg::BUCKET_W-1:0]     rsp_bucket,
	output logic [cht_pkg::POS_W-1:0]        rsp_position
);
	import cht_pkg::*;

	localparam int BKT_W     = $clog2(BUCKETS);
	localparam int SLOT_W    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int CNT_W     = $clog2(BUCKET_DEPTH + 1);
	localparam int ADDR_W    = BKT_W + SLOT_W;
	localparam int MEM_DEPTH = BUCKETS * (2 ** SLOT_W);
	localparam int MUL_W     = KEY_W + 1;
	localparam int PROD_W    = KEY_W + MUL_W;
	localparam int MOD_SH    = KEY_W + BKT_W;
	// Rounded-up reciprocal of the bucket count; exact for every key width input.
	localparam logic [MUL_W-1:0] MOD_M =
		MUL_W'(((64'd1 << MOD_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
	localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(BUCKET_DEPTH);

	// Current item.
	logic [OP_W-1:0]      op_q;
	logic [KEY_W-1:0]     key_q;
	logic [PROD_W-1:0]    prod_q;
	logic [MOD_CNT_W-1:0] mod_cnt_q;
	logic [BKT_W-1:0]     rem_q;
	logic [KEY_W-1:0]     mod_quot;
	logic [KEY_W-1:0]     mod_rem;

	// Fill count of the current bucket.
	logic [CNT_W-1:0]     fill_mem [BUCKETS];
	logic [BUCKETS-1:0]   fill_vld_q;
	logic [CNT_W-1:0]     fill_rd_q;
	logic                 fill_rv_q;
	logic [CNT_W-1:0]     fill_now;
	logic [CNT_W-1:0]     fill_q;
	logic [CNT_W-1:0]     fill_wr;

	// Slot walk and key memory pipeline.
	logic [KEY_W-1:0]     key_mem [MEM_DEPTH];
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     idx_m1;
	logic [CNT_W-1:0]     idx_p1;
	logic                 scan_issue;
	logic                 dn_more;
	logic                 hit;
	logic                 rd_en;
	logic [SLOT_W-1:0]    rd_slot;
	logic [KEY_W-1:0]     rd_q;
	logic                 tag_vld_s1;
	logic [SLOT_W-1:0]    slot_s1;
	logic                 we_s1;
	logic [ADDR_W-1:0]    wa_s1;
	logic                 src_key_s1;
	logic [KEY_W-1:0]     wr_data;
	logic [POS_W-1:0]     pos_q;

	// Result register.
	logic                 rsp_vld_q;
	logic                 out_free;

	// Quotient from the registered product, then the remainder of the key.
	assign mod_quot = KEY_W'(prod_q >> MOD_SH);
	assign mod_rem  = key_q - mod_quot * KEY_W'(BUCKETS);

	// Slot walk arithmetic.
	assign fill_now   = fill_rv_q ? fill_rd_q : '0;
	assign idx_m1     = idx_q - CNT_W'(1);
	assign idx_p1     = idx_q + CNT_W'(1);
	assign scan_issue = (idx_q < fill_q);
	assign dn_more    = (idx_p1 < fill_q);
	assign hit        = tag_vld_s1 && (rd_q == key_q);
	assign fill_wr    = (cmd.fill_op == FILL_INC) ? (fill_q + CNT_W'(1)) : (fill_q - CNT_W'(1));
	assign wr_data    = src_key_s1 ? key_q : rd_q;
	assign out_free   = !rsp_vld_q || rsp_ready;

	// Key memory read address for the walk that is running.
	always_comb begin
		rd_en   = 1'b0;
		rd_slot = idx_q[SLOT_W-1:0];
		if (cmd.shift_up && (idx_q != '0)) begin
			rd_en   = 1'b1;
			rd_slot = idx_m1[SLOT_W-1:0];
		end
		if (cmd.scan && scan_issue) begin
			rd_en = 1'b1;
		end
		if (cmd.shift_dn && dn_more) begin
			rd_en   = 1'b1;
			rd_slot = idx_p1[SLOT_W-1:0];
		end
	end

	// Key memory: one registered read and one write per cycle.
	always_ff @(posedge clk) begin
		if (we_s1) begin
			key_mem[wa_s1] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= key_mem[{rem_q, rd_slot}];
		end
	end

	// Fill count memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.post && (cmd.fill_op != FILL_KEEP)) begin
			fill_mem[rem_q] <= fill_wr;
		end
		if (cmd.fill_rd) begin
			fill_rd_q <= fill_mem[rem_q];
			fill_rv_q <= fill_vld_q[rem_q];
		end
	end

	// Control flags: fill valid bits, pipeline valids and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q <= '0;
			tag_vld_s1 <= 1'b0;
			we_s1      <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (cmd.post && (cmd.fill_op != FILL_KEEP)) begin
				fill_vld_q[rem_q] <= 1'b1;
			end
			tag_vld_s1 <= cmd.scan && scan_issue;
			we_s1      <= cmd.shift_up || (cmd.shift_dn && dn_more);
			if (cmd.post) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// Item, walk and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= req_operation;
			key_q     <= req_key;
			mod_cnt_q <= '0;
			rem_q     <= '0;
			pos_q     <= '0;
		end
		if (cmd.mod_step) begin
			prod_q    <= PROD_W'(key_q) * PROD_W'(MOD_M);
			if (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
				rem_q <= mod_rem[BKT_W-1:0];
			end
			mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
		end
		if (cmd.fill_ld) begin
			fill_q <= fill_now;
			idx_q  <= (op_q == OP_INSERT) ? fill_now : '0;
		end
		if (cmd.shift_up && (idx_q != '0)) begin
			idx_q <= idx_m1;
		end
		if (cmd.scan) begin
			if (hit) begin
				idx_q <= CNT_W'(slot_s1);
				pos_q <= POS_W'(CNT_W'(slot_s1) + CNT_W'(1));
			end else if (scan_issue) begin
				idx_q <= idx_p1;
			end
		end
		if (cmd.shift_dn && dn_more) begin
			idx_q <= idx_p1;
		end
		// Write stage: the destination is always the current slot.
		slot_s1    <= idx_q[SLOT_W-1:0];
		wa_s1      <= {rem_q, idx_q[SLOT_W-1:0]};
		src_key_s1 <= cmd.shift_up && (idx_q == '0);
		if (cmd.post) begin
			rsp_status   <= cmd.status;
			rsp_bucket   <= BUCKET_W'(rem_q);
			rsp_position <= pos_q;
		end
	end

	// Status to the controller.
	always_comb begin
		stat           = '0;
		stat.mod_last  = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
		stat.is_insert = (op_q == OP_INSERT);
		stat.is_delete = (op_q == OP_DELETE);
		stat.full      = (fill_now >= DEPTH_C);
		stat.up_done   = (idx_q == '0);
		stat.hit       = hit;
		stat.miss      = !tag_vld_s1 && !scan_issue;
		stat.dn_done   = !dn_more;
		stat.out_free  = out_free;
	end

	assign rsp_valid = rsp_vld_q;

	// Memory writes stay inside the bucket of the current item.
	`CHT_ASSERT(a_write_in_bucket, clk, arst_n, we_s1 |-> (wa_s1[ADDR_W-1:SLOT_W] == rem_q))
	// A compared slot always lies below the bucket fill.
	`CHT_ASSERT(a_scan_in_fill, clk, arst_n, tag_vld_s1 |-> (CNT_W'(slot_s1) < fill_q))
	// An insert never grows a bucket past its depth.
	`CHT_ASSERT_NEVER(a_fill_overflow, clk, arst_n, cmd.post && (cmd.fill_op == FILL_INC) && (fill_q >= DEPTH_C))
	// A delete never shrinks an empty bucket.
	`CHT_ASSERT_NEVER(a_fill_underflow, clk, arst_n, cmd.post && (cmd.fill_op == FILL_DEC) && (fill_q == '0))
	// A result appears only after the controller posts one.
	`CHT_ASSERT(a_rsp_from_post, clk, arst_n, $rose(rsp_vld_q) |-> $past(cmd.post))

endmodule

`default_nettype wire

// ===== sv/cht_ctrl.sv =====
// ---------------------------------------------------------------------------
// Hash table controller
// State machine that sequences one item through the modulo, fill lookup,
// scan or shift, and result phases of the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module cht_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     req_valid,
	output logic                    ready,
	output cht_pkg::cht_cmd_t       cmd,
	input  wire cht_pkg::cht_stat_t stat
);
	import cht_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_FILL_RD,
		S_FILL_LD,
		S_SHIFT_UP,
		S_SCAN,
		S_SHIFT_DN,
		S_POST
	} state_t;

	state_t              state_q;
	logic [STATUS_W-1:0] res_status_q;
	fill_op_t            res_fill_q;

	// Command decode from the current state.
	always_comb begin
		cmd         = '0;
		cmd.fill_op = res_fill_q;
		cmd.status  = res_status_q;
		case (state_q)
			S_IDLE:     cmd.load     = req_valid;
			S_MOD:      cmd.mod_step = 1'b1;
			S_FILL_RD:  cmd.fill_rd  = 1'b1;
			S_FILL_LD:  cmd.fill_ld  = 1'b1;
			S_SHIFT_UP: cmd.shift_up = 1'b1;
			S_SCAN:     cmd.scan     = 1'b1;
			S_SHIFT_DN: cmd.shift_dn = 1'b1;
			S_POST:     cmd.post     = stat.out_free;
			default:    cmd.load     = 1'b0;
		endcase
	end

	assign ready = (state_q == S_IDLE);

	// State and the result code held for the post phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_status_q <= STAT_OK;
			res_fill_q   <= FILL_KEEP;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (stat.mod_last) begin
						state_q <= S_FILL_RD;
					end
				end
				S_FILL_RD: begin
					state_q <= S_FILL_LD;
				end
				S_FILL_LD: begin
					if (!stat.is_insert) begin
						state_q <= S_SCAN;
					end else if (stat.full) begin
						res_status_q <= STAT_FULL;
						res_fill_q   <= FILL_KEEP;
						state_q      <= S_POST;
					end else begin
						state_q <= S_SHIFT_UP;
					end
				end
				S_SHIFT_UP: begin
					if (stat.up_done) begin
						res_status_q <= STAT_OK;
						res_fill_q   <= FILL_INC;
						state_q      <= S_POST;
					end
				end
				S_SCAN: begin
					if (stat.hit) begin
						res_status_q <= STAT_OK;
						if (stat.is_delete) begin
							res_fill_q <= FILL_DEC;
							state_q    <= S_SHIFT_DN;
						end else begin
							res_fill_q <= FILL_KEEP;
							state_q    <= S_POST;
						end
					end else if (stat.miss) begin
						res_status_q <= STAT_MISSING;
						res_fill_q   <= FILL_KEEP;
						state_q      <= S_POST;
					end
				end
				S_SHIFT_DN: begin
					if (stat.dn_done) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/chained_hash_table.sv =====
// ---------------------------------------------------------------------------
// Chained hash table
// Bounded-bucket hash table with insert, find and delete of 31-bit keys.
// ---------------------------------------------------------------------------
// Usage:
// Items arrive on req (operation, key) with valid/ready; each gives exactly
// one item on rsp (status, bucket, position). One item is worked at a time.
// After the accepting edge the bucket index is computed (a reciprocal
// multiply, then a multiply-back and subtract), the bucket fill is read,
// then the bucket is walked one key memory slot per cycle through the
// single read port, and the result is posted. An insert into a full
// bucket goes straight from the fill read to the post, and the next item
// is taken in the cycle after its result is posted.
// The result sits in an output register; if rsp is stalled the block still
// finishes the next item and then holds it until the register is taken.
// Reset clears all bucket fills at once; key memory needs no clearing.

`default_nettype none

module chained_hash_table #(
	parameter int BUCKETS      = cht_pkg::BUCKETS_DEF,
	parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	cht_req_if.sink   req,
	cht_rsp_if.source rsp
);
	import cht_pkg::*;

	cht_cmd_t  cmd;
	cht_stat_t stat;

	// Sequencer.
	cht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.ready     (req.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Storage, arithmetic and result register.
	cht_datapath #(
		.BUCKETS      (BUCKETS),
		.BUCKET_DEPTH (BUCKET_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_operation (req.operation),
		.req_key       (req.key),
		.cmd           (cmd),
		.stat          (stat),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.rsp_status    (rsp.status),
		.rsp_bucket    (rsp.bucket),
		.rsp_position  (rsp.position)
	);

endmodule

`default_nettype wire
